// ===== hw/rtl/ffmrd_pkg.sv =====
// shared constants, types and handshake structs for the first-fit dispatch core
`timescale 1ns / 1ps
`default_nettype none
package ffmrd_pkg;

   // pool geometry
   localparam int WORKER_COUNT     = 10;
   localparam int SLOTS_PER_WORKER = 10;

   // derived widths
   localparam int WID_W  = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;
   localparam int CNT_W  = $clog2(WORKER_COUNT + 1);
   localparam int SLOT_W = (SLOTS_PER_WORKER > 1) ? $clog2(SLOTS_PER_WORKER) : 1;
   localparam int CMP_W  = 9;

   // field widths
   localparam int AMT_W      = 16;
   localparam int FIELD_W    = 4;
   localparam int CFG_W      = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   typedef logic [AMT_W-1:0] amount_type;

   // opcodes
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic advance;
      logic set_hit;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_dispatch;
      logic at_end;
      logic fit;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ffmrd_ctrl.sv =====
// controller state machine for the first-fit dispatch core
`timescale 1ns / 1ps
`default_nettype none
module ffmrd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffmrd_pkg::status_type status,
   output ffmrd_pkg::cmd_type        cmd,
   output logic                      req_ready
);

   ffmrd_pkg::state_type state_ff;
   ffmrd_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffmrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffmrd_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               state_in = status.is_dispatch ? ffmrd_pkg::ST_SCAN : ffmrd_pkg::ST_FINISH;
            end
         end
         ffmrd_pkg::ST_SCAN: begin
            if (status.at_end || status.fit) begin
               state_in = ffmrd_pkg::ST_FINISH;
            end
         end
         ffmrd_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = ffmrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffmrd_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffmrd_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = status.req_valid;
         end
         ffmrd_pkg::ST_SCAN: begin
            cmd.set_hit = !status.at_end && status.fit;
            cmd.advance = !status.at_end && !status.fit;
         end
         ffmrd_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ffmrd_datapath.sv =====
// budget store, scan pointer and result register for the first-fit dispatch core
`timescale 1ns / 1ps
`default_nettype none
module ffmrd_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ffmrd_pkg::cmd_type                   cmd,
   output ffmrd_pkg::status_type                     status,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_opcode,
   input  wire logic [ffmrd_pkg::FIELD_W-1:0]        req_worker_index,
   input  wire ffmrd_pkg::amount_type                req_cpu_amount,
   input  wire ffmrd_pkg::amount_type                req_memory_amount,
   input  wire ffmrd_pkg::amount_type                req_network_amount,
   input  wire logic                                 csr_wen,
   input  wire logic [ffmrd_pkg::CFG_W-1:0]          csr_wdata,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic                                      rsp_accepted,
   output logic [ffmrd_pkg::FIELD_W-1:0]             rsp_assigned_worker,
   output logic [ffmrd_pkg::FIELD_W-1:0]             rsp_assigned_slot
);

   localparam logic [ffmrd_pkg::CMP_W-1:0] WC_CMP  = ffmrd_pkg::CMP_W'(ffmrd_pkg::WORKER_COUNT);
   localparam logic [ffmrd_pkg::CMP_W-1:0] SPW_CMP =
      ffmrd_pkg::CMP_W'(ffmrd_pkg::SLOTS_PER_WORKER);

   // per-worker state
   ffmrd_pkg::amount_type           cpu_bud_ff  [ffmrd_pkg::WORKER_COUNT];
   ffmrd_pkg::amount_type           mem_bud_ff  [ffmrd_pkg::WORKER_COUNT];
   ffmrd_pkg::amount_type           net_bud_ff  [ffmrd_pkg::WORKER_COUNT];
   logic [ffmrd_pkg::SLOT_W-1:0]    slot_ff     [ffmrd_pkg::WORKER_COUNT];

   // configuration and latched transaction
   logic [ffmrd_pkg::CFG_W-1:0]     active_ff;
   logic                            op_ff;
   logic [ffmrd_pkg::FIELD_W-1:0]   widx_ff;
   ffmrd_pkg::amount_type           cpu_ff;
   ffmrd_pkg::amount_type           mem_ff;
   ffmrd_pkg::amount_type           net_ff;
   logic [ffmrd_pkg::CMP_W-1:0]     lim_ff;
   logic [ffmrd_pkg::CMP_W-1:0]     lim_in;
   logic [ffmrd_pkg::CNT_W-1:0]     idx_ff;
   logic [ffmrd_pkg::CNT_W-1:0]     idx_in;
   logic                            hit_ff;
   logic                            hit_in;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_acc_ff;
   logic [ffmrd_pkg::FIELD_W-1:0]   rsp_worker_ff;
   logic [ffmrd_pkg::FIELD_W-1:0]   rsp_slot_ff;
   logic                            rsp_acc_in;
   logic [ffmrd_pkg::FIELD_W-1:0]   rsp_worker_in;
   logic [ffmrd_pkg::FIELD_W-1:0]   rsp_slot_in;

   logic [ffmrd_pkg::WID_W-1:0]     scan_addr;
   logic [ffmrd_pkg::WID_W-1:0]     load_addr;
   logic [ffmrd_pkg::CMP_W-1:0]     act_ext;
   logic [ffmrd_pkg::CMP_W-1:0]     idx_ext;
   logic [ffmrd_pkg::CMP_W-1:0]     widx_ext;
   logic [ffmrd_pkg::CMP_W-1:0]     slot_ext;
   logic [ffmrd_pkg::CMP_W-1:0]     slot_sum;
   logic [ffmrd_pkg::SLOT_W-1:0]    slot_next;
   logic                            at_end;
   logic                            fit;
   logic                            load_ok;
   logic                            is_load;
   logic                            do_load;
   logic                            do_take;

   // address and compare helpers
   always_comb begin
      scan_addr = idx_ff[ffmrd_pkg::WID_W-1:0];
      act_ext   = ffmrd_pkg::CMP_W'(active_ff);
      idx_ext   = ffmrd_pkg::CMP_W'(idx_ff);
      widx_ext  = ffmrd_pkg::CMP_W'(widx_ff);
      load_addr = widx_ext[ffmrd_pkg::WID_W-1:0];
      lim_in    = (act_ext > WC_CMP) ? WC_CMP : act_ext;
      at_end    = idx_ext >= lim_ff;
      load_ok   = widx_ext < WC_CMP;
      is_load   = op_ff == ffmrd_pkg::OP_LOAD;
   end

   // fit test on the worker under the scan pointer
   always_comb begin
      fit = !at_end
            && (cpu_bud_ff[scan_addr] >= cpu_ff)
            && (mem_bud_ff[scan_addr] >= mem_ff)
            && (net_bud_ff[scan_addr] >= net_ff);
   end

   // ring slot advance
   always_comb begin
      slot_ext  = ffmrd_pkg::CMP_W'(slot_ff[scan_addr]);
      slot_sum  = slot_ext + ffmrd_pkg::CMP_W'(1);
      slot_next = (slot_sum >= SPW_CMP) ? '0 : slot_sum[ffmrd_pkg::SLOT_W-1:0];
   end

   // scan pointer and hit flag
   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      if (cmd.accept) begin
         idx_in = '0;
         hit_in = 1'b0;
      end else begin
         if (cmd.advance) begin
            idx_in = idx_ff + ffmrd_pkg::CNT_W'(1);
         end
         if (cmd.set_hit) begin
            hit_in = 1'b1;
         end
      end
   end

   // result fields
   always_comb begin
      do_load       = cmd.finish && is_load && load_ok;
      do_take       = cmd.finish && !is_load && hit_ff;
      rsp_acc_in    = is_load ? load_ok : hit_ff;
      rsp_worker_in = '0;
      rsp_slot_in   = '0;
      if (!is_load && hit_ff) begin
         rsp_worker_in = idx_ext[ffmrd_pkg::FIELD_W-1:0];
         rsp_slot_in   = slot_ext[ffmrd_pkg::FIELD_W-1:0];
      end
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            active_ff <= csr_wdata;
         end
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // latched transaction and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         widx_ff <= req_worker_index;
         cpu_ff  <= req_cpu_amount;
         mem_ff  <= req_memory_amount;
         net_ff  <= req_network_amount;
         lim_ff  <= lim_in;
      end
      if (cmd.finish) begin
         rsp_acc_ff    <= rsp_acc_in;
         rsp_worker_ff <= rsp_worker_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   // per-worker budgets and slots
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ffmrd_pkg::WORKER_COUNT; i++) begin
            cpu_bud_ff[i] <= '0;
            mem_bud_ff[i] <= '0;
            net_bud_ff[i] <= '0;
            slot_ff[i]    <= '0;
         end
      end else if (do_load) begin
         cpu_bud_ff[load_addr] <= cpu_ff;
         mem_bud_ff[load_addr] <= mem_ff;
         net_bud_ff[load_addr] <= net_ff;
      end else if (do_take) begin
         cpu_bud_ff[scan_addr] <= cpu_bud_ff[scan_addr] - cpu_ff;
         mem_bud_ff[scan_addr] <= mem_bud_ff[scan_addr] - mem_ff;
         net_bud_ff[scan_addr] <= net_bud_ff[scan_addr] - net_ff;
         slot_ff[scan_addr]    <= slot_next;
      end
   end

   // status back to the controller
   always_comb begin
      status.req_valid   = req_valid;
      status.is_dispatch = req_opcode == ffmrd_pkg::OP_DISPATCH;
      status.at_end      = at_end;
      status.fit         = fit;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_assigned_worker = rsp_worker_ff;
   assign rsp_assigned_slot   = rsp_slot_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_multi_resource_dispatch_core.sv =====
// top level of the first-fit multi-resource dispatch core
// Keeps cpu, memory and network budgets plus a ring slot for each of ten
// workers. A load transaction (tuser 0) sets one worker's budgets. A
// dispatch transaction (tuser 1) walks the active workers one per cycle,
// reading the budgets of the worker under the scan pointer through the
// single budget read port, until one fits or the scan reaches its end.
// Either transaction is held at its finish step while the previous
// response still waits in its output register. The first worker whose
// budgets all cover the costs is charged and reported with its slot; if
// none fits, the response carries accepted 0. One transaction is in
// flight at a time; the next is taken while the previous response waits
// in its output register. The user must write active_workers through
// csr_wen/csr_wdata only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_multi_resource_dispatch_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request: worker_index[3:0], cpu_amount[19:4], memory_amount[35:20],
   // network_amount[51:36], zero pad [55:52]
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [ffmrd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // request kind: opcode[0]
   input  wire logic [0:0]                            req_tuser,
   // response: assigned_worker[3:0], assigned_slot[7:4]
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [ffmrd_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // response flag: accepted[0]
   output logic [0:0]                                 rsp_tuser,
   // active_workers register
   input  wire logic                                  csr_wen,
   input  wire logic [ffmrd_pkg::CFG_W-1:0]           csr_wdata
);

   ffmrd_pkg::cmd_type                   cmd;
   ffmrd_pkg::status_type                status;
   logic                                 rsp_accepted;
   logic [ffmrd_pkg::FIELD_W-1:0]        rsp_worker;
   logic [ffmrd_pkg::FIELD_W-1:0]        rsp_slot;

   // controller
   ffmrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_tready)
   );

   // datapath
   ffmrd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_valid           (req_tvalid),
      .req_opcode          (req_tuser[0]),
      .req_worker_index    (req_tdata[3:0]),
      .req_cpu_amount      (req_tdata[19:4]),
      .req_memory_amount   (req_tdata[35:20]),
      .req_network_amount  (req_tdata[51:36]),
      .csr_wen             (csr_wen),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .rsp_accepted        (rsp_accepted),
      .rsp_assigned_worker (rsp_worker),
      .rsp_assigned_slot   (rsp_slot)
   );

   // response packing
   assign rsp_tdata = {rsp_slot, rsp_worker};
   assign rsp_tuser = rsp_accepted;

endmodule
`default_nettype wire

// ===== tb/tb_first_fit_multi_resource_dispatch_core.sv =====
// self-checking testbench for the first-fit multi-resource dispatch core
`timescale 1ns / 1ps
module tb_first_fit_multi_resource_dispatch_core;
   import ffmrd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int LONG_HOLD      = 400;
   localparam int MAX_REPORTS    = 10;

   localparam logic [CFG_W-1:0] ALL_WORKERS = CFG_W'(WORKER_COUNT);
   localparam logic [CFG_W-1:0] MAX_SCAN    = '1;
   localparam amount_type       FULL_AMOUNT = '1;

   // expected outcome of one transaction, as seen on the response channel
   typedef struct packed {
      logic       accepted;
      logic [3:0] worker;
      logic [3:0] slot;
   } grant_type;

   // receiver stall patterns
   typedef enum int {
      RX_STREAM,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_wen = 1'b0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // shadow copy of the pool state
   amount_type       cpu_left [WORKER_COUNT] = '{default: '0};
   amount_type       mem_left [WORKER_COUNT] = '{default: '0};
   amount_type       net_left [WORKER_COUNT] = '{default: '0};
   logic [7:0]       slot_ring[WORKER_COUNT] = '{default: '0};
   logic [CFG_W-1:0] scan_width = '0;

   grant_type pending_grants[$];
   grant_type got_grant;
   grant_type want_grant;
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;
   int        hold_request = 0;
   int        hold_left = 0;
   int        mode_left = 0;
   int        rx_tick = 0;
   rx_mode_type stall_mode = RX_STREAM;

   first_fit_multi_resource_dispatch_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // applies one request to the shadow pool and returns the grant it produces
   function automatic grant_type place_job(logic op, logic [3:0] widx, amount_type cpu,
                                           amount_type mem, amount_type net);
      grant_type g;
      int        limit;
      bit        found;
      g = '0;
      found = 1'b0;
      if (op == OP_LOAD) begin
         if (widx < WORKER_COUNT) begin
            cpu_left[widx] = cpu;
            mem_left[widx] = mem;
            net_left[widx] = net;
            g.accepted = 1'b1;
         end
      end else begin
         limit = (scan_width > WORKER_COUNT) ? WORKER_COUNT : int'(scan_width);
         // first worker whose three budgets all cover the costs
         for (int i = 0; i < limit && !found; i++) begin
            if (cpu_left[i] >= cpu && mem_left[i] >= mem && net_left[i] >= net) begin
               found = 1'b1;
               g.accepted = 1'b1;
               g.worker = i[3:0];
               g.slot = slot_ring[i][3:0];
               cpu_left[i] = cpu_left[i] - cpu;
               mem_left[i] = mem_left[i] - mem;
               net_left[i] = net_left[i] - net;
               slot_ring[i] = (slot_ring[i] + 8'd1 >= SLOTS_PER_WORKER) ? 8'd0
                                                                        : slot_ring[i] + 8'd1;
            end
         end
      end
      return g;
   endfunction

   // offers one request (called at a falling edge), waits for the handshake,
   // then keeps valid up inside a burst or drops it for a gap
   task automatic send_request(logic op, logic [3:0] widx, amount_type cpu, amount_type mem,
                               amount_type net);
      int gap;
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {4'b0000, net, mem, cpu, widx};
      do @(posedge clock); while (!req_tready);
      pending_grants.push_back(place_job(op, widx, cpu, mem, net));
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // stops offering and waits until every pending grant has come back
   task automatic drain_to_idle();
      req_tvalid = 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_scan_width(logic [CFG_W-1:0] width);
      drain_to_idle();
      csr_wen = 1'b1;
      csr_wdata = width;
      @(negedge clock);
      csr_wen = 1'b0;
      scan_width = width;
   endtask

   function automatic amount_type random_budget();
      logic [31:0] r;
      r = ($urandom_range(0, 9) < 7) ? $urandom_range(20000, 65535) : $urandom();
      return r[15:0];
   endfunction

   function automatic amount_type random_cost();
      logic [31:0] r;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         r = 0;
      else if (pick < 55)
         r = $urandom_range(0, 2000);
      else if (pick < 85)
         r = $urandom_range(0, 20000);
      else
         r = $urandom();
      return r[15:0];
   endfunction

   // mostly dispatches with modest costs, some loads, a few to missing workers
   task automatic send_random_request();
      logic [31:0] w;
      if ($urandom_range(0, 4) == 0) begin
         w = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
         send_request(OP_LOAD, w[3:0], random_budget(), random_budget(), random_budget());
      end else begin
         w = $urandom();
         send_request(OP_DISPATCH, w[3:0], random_cost(), random_cost(), random_cost());
      end
   endtask

   task automatic run_random_phase(logic [CFG_W-1:0] width, int count);
      write_scan_width(width);
      for (int i = 0; i < count; i++) send_random_request();
   endtask

   // register reset value scans nobody, then all workers with empty budgets
   task automatic test_reset_scan_width();
      send_request(OP_DISPATCH, 4'd0, '0, '0, '0);
      write_scan_width(ALL_WORKERS);
      send_request(OP_DISPATCH, 4'd0, '0, '0, '0);
   endtask

   // loads at both ends and past the pool, exact fits and one-off misses
   task automatic test_budget_loads();
      send_request(OP_LOAD, 4'd0, FULL_AMOUNT, FULL_AMOUNT, FULL_AMOUNT);
      send_request(OP_LOAD, 4'd9, 16'h5A5A, 16'hA5A5, 16'h0F0F);
      send_request(OP_LOAD, 4'd10, FULL_AMOUNT, FULL_AMOUNT, FULL_AMOUNT);
      send_request(OP_LOAD, 4'd15, FULL_AMOUNT, FULL_AMOUNT, FULL_AMOUNT);
      send_request(OP_DISPATCH, 4'd15, FULL_AMOUNT, FULL_AMOUNT, FULL_AMOUNT);
      send_request(OP_DISPATCH, 4'd0, 16'h5A5B, 16'hA5A5, 16'h0F0F);
      send_request(OP_DISPATCH, 4'd0, 16'h5A5A, 16'hA5A5, 16'h0F10);
      send_request(OP_DISPATCH, 4'd0, 16'h5A5A, 16'hA5A5, 16'h0F0F);
   endtask

   // one active worker takes enough jobs to wrap its slot ring
   task automatic test_slot_wrap();
      write_scan_width(4'd1);
      send_request(OP_LOAD, 4'd0, 16'd1000, 16'd1000, 16'd1000);
      for (int i = 0; i < SLOTS_PER_WORKER + 1; i++)
         send_request(OP_DISPATCH, 4'd0, 16'd1, 16'd1, 16'd1);
   endtask

   // scan width above the pool size stops at the last worker
   task automatic test_wide_scan();
      write_scan_width(MAX_SCAN);
      send_request(OP_LOAD, 4'd9, FULL_AMOUNT, FULL_AMOUNT, FULL_AMOUNT);
      send_request(OP_DISPATCH, 4'd3, 16'hF000, 16'hF000, 16'hF000);
      send_request(OP_DISPATCH, 4'd3, 16'hF000, 16'hF000, 16'hF000);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      write_scan_width(4'd7);
      hold_request = LONG_HOLD;
      for (int i = 0; i < 40; i++) send_random_request();
   endtask

   // sender stops until every grant is back, then resumes
   task automatic test_pause_until_drained();
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 20; i++) send_random_request();
         drain_to_idle();
      end
   endtask

   task automatic note_mismatch(string what, grant_type want, grant_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch (%0s): expected accepted=%0d worker=%0d slot=%0d, got accepted=%0d worker=%0d slot=%0d",
                  $realtime, what, want.accepted, want.worker, want.slot,
                  got.accepted, got.worker, got.slot);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_grant.accepted = rsp_tuser[0];
         got_grant.worker = rsp_tdata[3:0];
         got_grant.slot = rsp_tdata[7:4];
         if (pending_grants.size() == 0) begin
            note_mismatch("unexpected response", '0, got_grant);
         end else begin
            want_grant = pending_grants.pop_front();
            if (got_grant.accepted !== want_grant.accepted ||
                got_grant.worker !== want_grant.worker ||
                got_grant.slot !== want_grant.slot)
               note_mismatch("field", want_grant, got_grant);
         end
      end
   end

   // receiver stall patterns, with a long hold on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         rx_tick++;
         case (stall_mode)
            RX_STREAM:   rsp_tready = 1'b1;
            RX_RANDOM:   rsp_tready = ($urandom_range(0, 1) == 1);
            RX_PERIODIC: rsp_tready = (rx_tick % 4 == 0);
            default:     rsp_tready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL first_fit_multi_resource_dispatch_core");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_scan_width();
      test_budget_loads();
      test_slot_wrap();
      test_wide_scan();
      run_random_phase(ALL_WORKERS, 550);
      run_random_phase(4'd0, 100);
      run_random_phase(MAX_SCAN, 320);
      run_random_phase(4'd1, 160);
      run_random_phase(4'd5, 260);
      test_backpressure();
      test_pause_until_drained();
      run_random_phase(4'd9, 250);
      drain_to_idle();

      if (mismatch_count == 0 && pending_grants.size() == 0)
         $display("PASS first_fit_multi_resource_dispatch_core");
      else
         $display("FAIL first_fit_multi_resource_dispatch_core");
      $finish;
   end

endmodule
